// File: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic             CMD_PUT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESP   = 4'b1000
  } lkv_state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic touch;
    logic insert;
    logic ram_rd;
    logic ram_wr;
  } lkv_cmd_t;

  typedef struct packed {
    logic is_put;
    logic hit;
    logic slot_found;
  } lkv_sts_t;

endpackage

// File: rtl/lkv_ram.sv
// Generic single-port RAM with registered read data.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

// File: rtl/lkv_ctrl.sv
// Sequencing state machine for the LRU key-value cache.
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lkv_pkg::lkv_sts_t sts,
  output lkv_pkg::lkv_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);

  lkv_pkg::lkv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = lkv_pkg::ST_LOOKUP;
        end
      end
      lkv_pkg::ST_LOOKUP: begin
        cmd.search = 1'b1;
        state_nxt  = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        cmd.touch  = sts.hit;
        cmd.ram_rd = !sts.is_put && sts.hit;
        cmd.ram_wr = sts.is_put && (sts.hit || sts.slot_found);
        cmd.insert = sts.is_put && !sts.hit;
        state_nxt  = lkv_pkg::ST_RESP;
      end
      lkv_pkg::ST_RESP: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != lkv_pkg::ST_IDLE);
  assign out_valid = (state_r == lkv_pkg::ST_RESP);

endmodule

// File: rtl/lkv_datapath.sv
// Entry store, key match, recency ranks and value memory of the LRU key-value cache.
module lkv_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  input  logic                             cfg_wr,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_data,
  input  lkv_pkg::lkv_cmd_t                cmd,
  output lkv_pkg::lkv_sts_t                sts,
  output logic                             out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_evicted
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [ENTRIES-1:0]        valid_r, valid_nxt;
  logic [lkv_pkg::KEY_W-1:0] key_arr_r [ENTRIES];
  logic [IDX_W-1:0]          age_arr_r [ENTRIES];
  logic [IDX_W-1:0]          age_nxt   [ENTRIES];

  logic                      op_put_r;
  logic [lkv_pkg::KEY_W-1:0] op_key_r;
  logic [lkv_pkg::VAL_W-1:0] op_val_r;

  logic                      hit_r;
  logic [ENTRIES-1:0]        hit_oh_r;
  logic [IDX_W-1:0]          hit_idx_r;
  logic [IDX_W-1:0]          hit_age_r;
  logic                      evict_r;
  logic [ENTRIES-1:0]        victim_oh_r;
  logic [ENTRIES-1:0]        slot_oh_r;
  logic [IDX_W-1:0]          slot_idx_r;
  logic                      slot_found_r;

  logic [ENTRIES-1:0]        match_c;
  logic [IDX_W-1:0]          hit_idx_c;
  logic [IDX_W-1:0]          hit_age_c;
  logic [lkv_pkg::CAP_W-1:0] cap_eff_c;
  logic                      evict_need_c;
  logic                      evict_c;
  logic [IDX_W-1:0]          oldest_age_c;
  logic [ENTRIES-1:0]        victim_oh_c;
  logic [ENTRIES-1:0]        cand_c;
  logic [ENTRIES-1:0]        slot_oh_c;
  logic [IDX_W-1:0]          slot_idx_c;

  logic [IDX_W-1:0]          ram_addr;
  logic [lkv_pkg::VAL_W-1:0] ram_rdata;

  always_comb begin
    hit_idx_c    = '0;
    hit_age_c    = '0;
    slot_idx_c   = '0;
    oldest_age_c = IDX_W'(fill_r - CNT_W'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i]     = valid_r[i] && (key_arr_r[i] == op_key_r);
      victim_oh_c[i] = valid_r[i] && (age_arr_r[i] == oldest_age_c);
      if (match_c[i]) begin
        hit_idx_c = hit_idx_c | IDX_W'(i);
        hit_age_c = hit_age_c | age_arr_r[i];
      end
    end
    cap_eff_c    = (cap_r == '0) ? lkv_pkg::CAP_W'(1) : cap_r;
    evict_need_c = (CMP_W'(fill_r) >= CMP_W'(ENTRIES)) ||
                   (CMP_W'(fill_r) >= CMP_W'(cap_eff_c));
    evict_c      = op_put_r && (match_c == '0) && evict_need_c;
    cand_c       = ~valid_r | (evict_c ? victim_oh_c : '0);
    slot_oh_c    = cand_c & (~cand_c + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh_c[i]) begin
        slot_idx_c = slot_idx_c | IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_arr_r[i];
    end
    if (cmd.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_oh_r[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_arr_r[i] < hit_age_r)) begin
          age_nxt[i] = age_arr_r[i] + IDX_W'(1);
        end
      end
    end else if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_found_r && slot_oh_r[i]) begin
          valid_nxt[i] = 1'b1;
          age_nxt[i]   = '0;
        end else if (evict_r && victim_oh_r[i]) begin
          valid_nxt[i] = 1'b0;
        end else if (valid_r[i]) begin
          age_nxt[i] = age_arr_r[i] + IDX_W'(1);
        end
      end
      fill_nxt = fill_r - CNT_W'(evict_r) + CNT_W'(slot_found_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lkv_pkg::CAP_RESET;
      fill_r  <= '0;
      valid_r <= '0;
    end else begin
      if (cfg_wr) begin
        cap_r <= cfg_data;
      end
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_arr_r[i] <= age_nxt[i];
      if (cmd.insert && slot_found_r && slot_oh_r[i]) begin
        key_arr_r[i] <= op_key_r;
      end
    end
    if (cmd.load) begin
      op_put_r <= (in_cmd == lkv_pkg::CMD_PUT);
      op_key_r <= in_key;
      op_val_r <= in_value;
    end
    if (cmd.search) begin
      hit_r        <= (match_c != '0);
      hit_oh_r     <= match_c;
      hit_idx_r    <= hit_idx_c;
      hit_age_r    <= hit_age_c;
      evict_r      <= evict_c;
      victim_oh_r  <= victim_oh_c;
      slot_oh_r    <= slot_oh_c;
      slot_idx_r   <= slot_idx_c;
      slot_found_r <= (cand_c != '0);
    end
  end

  assign ram_addr = hit_r ? hit_idx_r : slot_idx_r;

  lkv_ram #(
    .WIDTH (lkv_pkg::VAL_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .re    (cmd.ram_rd),
    .addr  (ram_addr),
    .wdata (op_val_r),
    .rdata (ram_rdata)
  );

  assign sts.is_put     = op_put_r;
  assign sts.hit        = hit_r;
  assign sts.slot_found = slot_found_r;

  assign out_hit        = hit_r;
  assign out_evicted    = evict_r;
  assign out_read_value = (!op_put_r && hit_r) ? ram_rdata : '0;

endmodule

// File: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller, datapath and configuration port.
// Each request is one get or put. A transfer is taken when start is high and busy is low, and
// exactly one result follows: out_valid is high for one cycle, in the result state, and the
// receiver cannot hold it off. No new request is taken until that result has been shown. After
// the accepting edge the block passes through the lookup state (parallel key search and
// victim/free-slot pick), the update state (rank update with the value memory access) and the
// result state; busy stays high until the result state ends. The store starts empty after reset.
// The capacity register is written over the cfg channel, which is always ready; write it only
// while busy is low.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_evicted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_data
);

  lkv_pkg::lkv_cmd_t cmd;
  lkv_pkg::lkv_sts_t sts;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

endmodule

// File: rtl/lkv_checker.sv
// Port-level checks for the LRU key-value cache and their binding to the top level.
module lkv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic                             out_hit,
  input logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  input logic                             out_evicted
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("Result shown while the block is not busy.");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transfer did not raise busy.");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("More than one result for one transfer.");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_read_value == '0))
    else $error("Miss returned a nonzero value.");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit)
    else $error("Eviction reported on a hit.");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_read_value (out_read_value),
  .out_evicted    (out_evicted)
);
